[design/asd_pkg.sv]
// asd_pkg: shared types and constants for the ARP spoofing detector.
// Used by asd_ctrl, asd_datapath and arp_spoof_detector. No dependencies.
package asd_pkg;

   localparam int REQUESTER_DEPTH_DEF = 128;
   localparam int RESPONDER_DEPTH_DEF = 4;

   localparam int OP_W  = 16;
   localparam int MAC_W = 48;
   localparam int IP_W  = 32;
   localparam int THR_W = 3;
   localparam int CNT_OUT_W = 3;

   localparam logic [OP_W-1:0]  OP_REQUEST = 16'd1;
   localparam logic [OP_W-1:0]  OP_REPLY   = 16'd2;
   localparam logic [THR_W-1:0] THR_RESET  = 3'd2;

   // CSR map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_THR_ADDR = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ_SCAN,
      ST_CNT_RD,
      ST_CNT_LD,
      ST_RSP_SCAN,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture the input transaction
      logic scan_start;  // rewind the scan counter
      logic scan;        // scan step
      logic sel_rsp;     // 0: requester table, 1: responder list
      logic req_write;   // append sender pair to requester table
      logic rsp_write;   // append sender pair to responder list
      logic cnt_read;    // read responder count of matched requester
      logic cnt_load;    // latch that count
      logic drop_set;    // table full, flag the result
      logic out_load;    // load the result register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_request;
      logic is_reply;
      logic hit;
      logic done;
      logic req_full;
      logic rsp_full;
      logic out_busy;
   } dp_status_type;

endpackage

[design/asd_ctrl.sv]
// asd_ctrl: sequencing state machine of the ARP spoofing detector.
// Depends on asd_pkg; drives asd_datapath through dp_cmd_type.
module asd_ctrl
   import asd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FINISH;
               if (status.is_request || status.is_reply) begin
                  state_in = ST_REQ_SCAN;
               end
            end
         end
         ST_REQ_SCAN: begin
            if (status.hit) begin
               state_in = status.is_reply ? ST_CNT_RD : ST_FINISH;
            end else if (status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_CNT_RD:   state_in = ST_CNT_LD;
         ST_CNT_LD:   state_in = ST_RSP_SCAN;
         ST_RSP_SCAN: begin
            if (status.hit || status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.load       = req_valid;
            cmd.scan_start = req_valid;
         end
         ST_REQ_SCAN: begin
            cmd.scan = 1'b1;
            if (!status.hit && status.done && status.is_request) begin
               cmd.drop_set  = status.req_full;
               cmd.req_write = !status.req_full;
            end
         end
         ST_CNT_RD: cmd.cnt_read = 1'b1;
         ST_CNT_LD: begin
            cmd.cnt_load   = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.sel_rsp    = 1'b1;
         end
         ST_RSP_SCAN: begin
            cmd.scan    = 1'b1;
            cmd.sel_rsp = 1'b1;
            if (!status.hit && status.done) begin
               cmd.drop_set  = status.rsp_full;
               cmd.rsp_write = !status.rsp_full;
            end
         end
         ST_FINISH: cmd.out_load = !status.out_busy;
         default: ;
      endcase
   end

endmodule

[design/asd_datapath.sv]
// asd_datapath: tables, scan counter, compare and result register.
// Depends on asd_pkg; controlled by asd_ctrl.
module asd_datapath
   import asd_pkg::*;
#(
   parameter int REQUESTER_DEPTH = REQUESTER_DEPTH_DEF,
   parameter int RESPONDER_DEPTH = RESPONDER_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OP_W-1:0]      req_op,
   input  logic [MAC_W-1:0]     req_sender_mac,
   input  logic [IP_W-1:0]      req_sender_ip,
   input  logic [MAC_W-1:0]     req_target_mac,
   input  logic [IP_W-1:0]      req_target_ip,
   input  logic [THR_W-1:0]     threshold,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_attack,
   output logic [MAC_W-1:0]     rsp_victim_mac,
   output logic [IP_W-1:0]      rsp_victim_ip,
   output logic [CNT_OUT_W-1:0] rsp_responder_count,
   output logic                 rsp_dropped,
   input  dp_cmd_type           cmd,
   output dp_status_type        status
);

   localparam int REQ_IDX_W  = (REQUESTER_DEPTH > 1) ? $clog2(REQUESTER_DEPTH) : 1;
   localparam int REQ_CNT_W  = $clog2(REQUESTER_DEPTH + 1);
   localparam int RSP_CNT_W  = $clog2(RESPONDER_DEPTH + 1);
   localparam int RSP_TOTAL  = REQUESTER_DEPTH * RESPONDER_DEPTH;
   localparam int RSP_ADDR_W = $clog2(RSP_TOTAL);
   localparam int SCAN_W     = (REQ_CNT_W > RSP_CNT_W) ? REQ_CNT_W : RSP_CNT_W;
   localparam int CMP_W      = (RSP_CNT_W > THR_W) ? RSP_CNT_W : THR_W;
   localparam int PAIR_W     = MAC_W + IP_W;

   // memories
   logic [PAIR_W-1:0]    req_mem [REQUESTER_DEPTH];
   logic [PAIR_W-1:0]    rsp_mem [RSP_TOTAL];
   logic [RSP_CNT_W-1:0] used_mem [REQUESTER_DEPTH];

   logic [OP_W-1:0]       op_ff;
   logic [MAC_W-1:0]      smac_ff, tmac_ff;
   logic [IP_W-1:0]       sip_ff, tip_ff;
   logic [PAIR_W-1:0]     req_rd_ff, rsp_rd_ff;
   logic [RSP_CNT_W-1:0]  used_rd_ff;
   logic [REQ_CNT_W-1:0]  req_used_ff;
   logic [SCAN_W-1:0]     idx_ff;
   logic                  pend_ff;
   logic                  matched_ff;
   logic                  drop_ff;
   logic [REQ_IDX_W-1:0]  r_ff;
   logic [RSP_ADDR_W-1:0] base_ff;
   logic [RSP_CNT_W-1:0]  cnt_ff;
   logic                  rsp_valid_ff;
   logic                  attack_ff, dropped_ff;
   logic [MAC_W-1:0]      vmac_ff;
   logic [IP_W-1:0]       vip_ff;
   logic [CNT_OUT_W-1:0]  count_ff;

   logic                  is_request, is_reply;
   logic [PAIR_W-1:0]     key, rd_pair;
   logic [SCAN_W-1:0]     limit, hit_idx;
   logic                  hit, issue;
   logic [RSP_ADDR_W-1:0] rsp_rd_addr, rsp_wr_addr;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  rep;

   assign is_request = (op_ff == OP_REQUEST);
   assign is_reply   = (op_ff == OP_REPLY);

   // scan compare: key is the sender pair except for a requester lookup of a reply
   assign key     = (cmd.sel_rsp || is_request) ? {smac_ff, sip_ff} : {tmac_ff, tip_ff};
   assign rd_pair = cmd.sel_rsp ? rsp_rd_ff : req_rd_ff;
   assign limit   = cmd.sel_rsp ? SCAN_W'(cnt_ff) : SCAN_W'(req_used_ff);
   assign hit     = pend_ff && (rd_pair == key);
   assign issue   = cmd.scan && !hit && (idx_ff < limit);
   assign hit_idx = idx_ff - SCAN_W'(1);

   assign rsp_rd_addr = base_ff + RSP_ADDR_W'(idx_ff);
   assign rsp_wr_addr = base_ff + RSP_ADDR_W'(cnt_ff);

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         smac_ff <= req_sender_mac;
         sip_ff  <= req_sender_ip;
         tmac_ff <= req_target_mac;
         tip_ff  <= req_target_ip;
      end
   end

   // scan counter and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         req_used_ff <= '0;
         matched_ff  <= 1'b0;
         drop_ff     <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= issue || hit;
         end
         if (cmd.req_write) begin
            req_used_ff <= req_used_ff + REQ_CNT_W'(1);
         end
         if (cmd.load) begin
            matched_ff <= 1'b0;
         end else if (cmd.scan && !cmd.sel_rsp && hit) begin
            matched_ff <= 1'b1;
         end
         if (cmd.load) begin
            drop_ff <= 1'b0;
         end else if (cmd.drop_set) begin
            drop_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + SCAN_W'(1);
      end
      // matched requester index and its responder list base
      if (cmd.scan && !cmd.sel_rsp && hit) begin
         r_ff    <= hit_idx[REQ_IDX_W-1:0];
         base_ff <= RSP_ADDR_W'(hit_idx * RESPONDER_DEPTH);
      end
      if (cmd.cnt_load) begin
         cnt_ff <= used_rd_ff;
      end else if (cmd.rsp_write) begin
         cnt_ff <= cnt_ff + RSP_CNT_W'(1);
      end
   end

   // requester table
   always_ff @(posedge clock) begin
      if (cmd.req_write) begin
         req_mem[req_used_ff[REQ_IDX_W-1:0]] <= {smac_ff, sip_ff};
      end
      if (issue && !cmd.sel_rsp) begin
         req_rd_ff <= req_mem[idx_ff[REQ_IDX_W-1:0]];
      end
   end

   // responder lists
   always_ff @(posedge clock) begin
      if (cmd.rsp_write) begin
         rsp_mem[rsp_wr_addr] <= {smac_ff, sip_ff};
      end
      if (issue && cmd.sel_rsp) begin
         rsp_rd_ff <= rsp_mem[rsp_rd_addr];
      end
   end

   // responder counts, cleared per requester when it is allocated
   always_ff @(posedge clock) begin
      if (cmd.req_write) begin
         used_mem[req_used_ff[REQ_IDX_W-1:0]] <= '0;
      end else if (cmd.rsp_write) begin
         used_mem[r_ff] <= cnt_ff + RSP_CNT_W'(1);
      end
      if (cmd.cnt_read) begin
         used_rd_ff <= used_mem[r_ff];
      end
   end

   // result register
   assign rep     = is_reply && matched_ff;
   assign cnt_ext = CMP_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         attack_ff  <= rep && (cnt_ext >= CMP_W'(threshold));
         vmac_ff    <= rep ? tmac_ff : '0;
         vip_ff     <= rep ? tip_ff : '0;
         count_ff   <= !rep ? '0 :
                       (cnt_ext > CMP_W'(7)) ? CNT_OUT_W'(7) : cnt_ext[CNT_OUT_W-1:0];
         dropped_ff <= drop_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_attack          = attack_ff;
   assign rsp_victim_mac      = vmac_ff;
   assign rsp_victim_ip       = vip_ff;
   assign rsp_responder_count = count_ff;
   assign rsp_dropped         = dropped_ff;

   // status back to the controller; in IDLE the opcode is still on the input
   always_comb begin
      status            = '0;
      status.is_request = cmd.load ? (req_op == OP_REQUEST) : is_request;
      status.is_reply   = cmd.load ? (req_op == OP_REPLY) : is_reply;
      status.hit        = hit;
      status.done       = !pend_ff && (idx_ff >= limit);
      status.req_full   = (req_used_ff == REQ_CNT_W'(REQUESTER_DEPTH));
      status.rsp_full   = (cnt_ff == RSP_CNT_W'(RESPONDER_DEPTH));
      status.out_busy   = rsp_valid_ff && rsp_stall;
   end

endmodule

[design/arp_spoof_detector.sv]
// arp_spoof_detector: top level; CSR port, controller and datapath.
// Other opcodes go straight to the result; a request scans the requester table, and a reply
// scans it and then the responder list of the match, one table read a cycle.
// Throughput: one transaction at a time; req_stall drops in the cycle after the result loads.
// Reset (synchronous): requester count, flags and handshake clear, threshold to 2; tables keep data.
module arp_spoof_detector
   import asd_pkg::*;
#(
   parameter int REQUESTER_DEPTH = REQUESTER_DEPTH_DEF,
   parameter int RESPONDER_DEPTH = RESPONDER_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [MAC_W-1:0]      req_sender_mac,
   input  logic [IP_W-1:0]       req_sender_ip,
   input  logic [MAC_W-1:0]      req_target_mac,
   input  logic [IP_W-1:0]       req_target_ip,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_attack,
   output logic [MAC_W-1:0]      rsp_victim_mac,
   output logic [IP_W-1:0]       rsp_victim_ip,
   output logic [CNT_OUT_W-1:0]  rsp_responder_count,
   output logic                  rsp_dropped,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [THR_W-1:0] thr_ff;
   dp_cmd_type       cmd;
   dp_status_type    status;

   // single CSR: alarm threshold at word 0
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_THR_ADDR) ? CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && pready && (paddr == CSR_THR_ADDR)) begin
         thr_ff <= pwdata[THR_W-1:0];
      end
   end

   asd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   asd_datapath #(
      .REQUESTER_DEPTH (REQUESTER_DEPTH),
      .RESPONDER_DEPTH (RESPONDER_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_op              (req_op),
      .req_sender_mac      (req_sender_mac),
      .req_sender_ip       (req_sender_ip),
      .req_target_mac      (req_target_mac),
      .req_target_ip       (req_target_ip),
      .threshold           (thr_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_attack          (rsp_attack),
      .rsp_victim_mac      (rsp_victim_mac),
      .rsp_victim_ip       (rsp_victim_ip),
      .rsp_responder_count (rsp_responder_count),
      .rsp_dropped         (rsp_dropped),
      .cmd                 (cmd),
      .status              (status)
   );

`ifndef SYNTHESIS
   // an accepted transaction makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a transaction is in progress");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid && rsp_stall))
      else $error("result register overwritten");

   // no append into a full table
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      !(cmd.req_write && status.req_full) && !(cmd.rsp_write && status.rsp_full))
      else $error("write into a full table");
`endif

endmodule

[tb/tb_arp_spoof_detector.sv]
// tb_arp_spoof_detector: self-checking testbench for the ARP spoofing detector.
// Depends on asd_pkg and arp_spoof_detector; predicts each result and checks it.
module tb_arp_spoof_detector;
   import asd_pkg::*;

   localparam int NREQ = REQUESTER_DEPTH_DEF;
   localparam int NRSP = RESPONDER_DEPTH_DEF;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic                 attack;
      logic [MAC_W-1:0]     victim_mac;
      logic [IP_W-1:0]      victim_ip;
      logic [CNT_OUT_W-1:0] count;
      logic                 dropped;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [OP_W-1:0]  req_op = '0;
   logic [MAC_W-1:0] req_sender_mac = '0, req_target_mac = '0;
   logic [IP_W-1:0]  req_sender_ip = '0, req_target_ip = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_attack;
   logic [MAC_W-1:0] rsp_victim_mac;
   logic [IP_W-1:0]  rsp_victim_ip;
   logic [CNT_OUT_W-1:0] rsp_responder_count;
   logic rsp_dropped;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   arp_spoof_detector dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow tables of the detector
   logic [MAC_W-1:0] host_mac [NREQ];
   logic [IP_W-1:0]  host_ip  [NREQ];
   int               host_cnt;
   int               peer_cnt [NREQ];
   logic [MAC_W-1:0] peer_mac [NREQ][NRSP];
   logic [IP_W-1:0]  peer_ip  [NREQ][NRSP];
   logic [THR_W-1:0] threshold = THR_RESET;

   verdict_type pending_verdicts[$];
   int mismatches = 0, verdicts_seen = 0, cycles = 0, sent = 0;
   int gap_max = 4;
   bit stall_on = 1;

   // pool of addresses so replies hit stored requesters
   logic [MAC_W-1:0] pool_mac [16];
   logic [IP_W-1:0]  pool_ip  [16];

   function automatic int lookup_host(logic [MAC_W-1:0] m, logic [IP_W-1:0] a);
      for (int i = 0; i < host_cnt; i++)
         if (host_mac[i] == m && host_ip[i] == a) return i;
      return -1;
   endfunction

   // update shadow state and return the expected verdict
   function automatic verdict_type detect(logic [OP_W-1:0] op, logic [MAC_W-1:0] smac,
                                          logic [IP_W-1:0] sip, logic [MAC_W-1:0] tmac,
                                          logic [IP_W-1:0] tip);
      verdict_type v;
      int r;
      bit known;
      v = '0;
      if (op == OP_REQUEST) begin
         if (lookup_host(smac, sip) < 0) begin
            if (host_cnt < NREQ) begin
               host_mac[host_cnt] = smac;
               host_ip[host_cnt] = sip;
               peer_cnt[host_cnt] = 0;
               host_cnt++;
            end else begin
               v.dropped = 1;
            end
         end
      end else if (op == OP_REPLY) begin
         r = lookup_host(tmac, tip);
         if (r >= 0) begin
            known = 0;
            for (int j = 0; j < peer_cnt[r]; j++)
               if (peer_mac[r][j] == smac && peer_ip[r][j] == sip) known = 1;
            if (!known) begin
               if (peer_cnt[r] < NRSP) begin
                  peer_mac[r][peer_cnt[r]] = smac;
                  peer_ip[r][peer_cnt[r]] = sip;
                  peer_cnt[r]++;
               end else begin
                  v.dropped = 1;
               end
            end
            v.attack = (peer_cnt[r] >= threshold);
            v.victim_mac = host_mac[r];
            v.victim_ip = host_ip[r];
            v.count = (peer_cnt[r] > 7) ? 3'd7 : peer_cnt[r][2:0];
         end
      end
      return v;
   endfunction

   // send one transaction, with a random gap before it
   task automatic send_arp(logic [OP_W-1:0] op, logic [MAC_W-1:0] smac,
                           logic [IP_W-1:0] sip, logic [MAC_W-1:0] tmac,
                           logic [IP_W-1:0] tip);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
      repeat (gap + 1) @(negedge clock);
      req_valid <= 1;
      req_op <= op;
      req_sender_mac <= smac;
      req_sender_ip <= sip;
      req_target_mac <= tmac;
      req_target_ip <= tip;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(detect(op, smac, sip, tmac, tip));
      sent++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (NREQ + 2 * NRSP + 20) @(negedge clock);
   endtask

   // register write: setup then access phase
   task automatic write_threshold(logic [THR_W-1:0] value);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= CSR_THR_ADDR; pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      threshold = value;
   endtask

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   // extremes and every opcode class
   task automatic test_directed();
      send_arp(16'hFFFF, '1, '1, '1, '1);
      send_arp('0, '0, '0, '0, '0);
      send_arp(OP_REPLY, '1, '1, '0, '0);
      send_arp(OP_REQUEST, '0, '0, '1, '1);
      send_arp(OP_REQUEST, '1, '1, '0, '0);
      send_arp(OP_REQUEST, '1, '1, '0, '0);
      for (int k = 0; k < 6; k++)
         send_arp(OP_REPLY, {k[15:0], 32'hA5A5_0000}, k, '1, '1);
      send_arp(OP_REPLY, 48'hA5A5_0000, 0, '1, '1);
      send_arp(OP_REPLY, 48'h1, 1, '0, '0);
      send_arp(OP_REPLY, 48'h1, 1, '0, '0);
      send_arp(16'h0003, '1, '1, '1, '1);
   endtask

   // threshold sweep including out-of-range settings
   task automatic test_thresholds();
      logic [THR_W-1:0] levels [6] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd7, 3'd2};
      foreach (levels[i]) begin
         drain();
         write_threshold(levels[i]);
         for (int k = 0; k < 5; k++)
            send_arp(OP_REPLY, rand_mac(), $urandom(), '1, '1);
         send_arp(OP_REPLY, 48'h5, 5, '0, '0);
      end
   endtask

   // mostly well-formed traffic over a small address pool
   task automatic test_random(int n);
      int a, b, sel;
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(0, 15);
         b = $urandom_range(0, 15);
         sel = $urandom_range(0, 9);
         if (sel < 3)
            send_arp(OP_REQUEST, pool_mac[a], pool_ip[a], rand_mac(), $urandom());
         else if (sel < 8)
            send_arp(OP_REPLY, pool_mac[b], pool_ip[b], pool_mac[a], pool_ip[a]);
         else if (sel < 9)
            send_arp(OP_W'($urandom()), rand_mac(), $urandom(), rand_mac(), $urandom());
         else
            send_arp(OP_REPLY, rand_mac(), $urandom(), rand_mac(), $urandom());
         if (i % 200 == 199) gap_max = (gap_max == 4) ? 30 : 4;
      end
   endtask

   // fill the requester table and overflow it
   task automatic test_table_full();
      drain();
      while (host_cnt < NREQ)
         send_arp(OP_REQUEST, rand_mac(), $urandom(), '0, '0);
      repeat (3) send_arp(OP_REQUEST, rand_mac(), $urandom(), '0, '0);
      send_arp(OP_REPLY, rand_mac(), $urandom(), host_mac[NREQ - 1], host_ip[NREQ - 1]);
      send_arp(OP_REQUEST, host_mac[0], host_ip[0], '0, '0);
      for (int k = 0; k < 40; k++)
         send_arp(OP_REQUEST, rand_mac(), $urandom(), '0, '0);
      test_random(200);
   endtask

   // receiver stall pattern, with quiet stretches
   always @(negedge clock) begin
      if (cycles % 500 == 0) stall_on <= ($urandom_range(0, 2) != 0);
      rsp_stall <= stall_on && ($urandom_range(0, 3) == 0);
   end

   // result checker
   always @(posedge clock) begin
      verdict_type want, got;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_attack, rsp_victim_mac, rsp_victim_ip, rsp_responder_count,
                 rsp_dropped};
         verdicts_seen <= verdicts_seen + 1;
         if (pending_verdicts.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %p", got);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("arp_spoof_detector verification failed");
         $finish;
      end
   end

   initial begin
      host_cnt = 0;
      foreach (pool_mac[i]) begin
         pool_mac[i] = (i == 0) ? '1 : rand_mac();
         pool_ip[i] = (i == 1) ? '0 : $urandom();
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_thresholds();
      drain();
      write_threshold(3'd3);
      test_random(500);
      // hold off until every result is back, then continue
      drain();
      write_threshold(3'd2);
      test_random(400);
      test_table_full();
      drain();
      $display("sent %0d ARP transactions, checked %0d results", sent, verdicts_seen);
      $display("covered thresholds 0, 1, 2, 3, 4 and 7, full responder lists, full table");
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("arp_spoof_detector verification clean");
      else
         $display("arp_spoof_detector verification failed");
      $finish;
   end
endmodule

[arp_spoof_detector.f]
design/asd_pkg.sv
design/asd_ctrl.sv
design/asd_datapath.sv
design/arp_spoof_detector.sv
tb/tb_arp_spoof_detector.sv
